// ===== design/rssi_histogram_noise_floor_top_assert.svh =====
// Assertion macros for the RSSI histogram noise-floor block.
// Used by rssi_histogram_noise_floor_top; expects clk_i and rst_ni in scope.
`ifndef RSSI_HISTOGRAM_NOISE_FLOOR_TOP_ASSERT_SVH
`define RSSI_HISTOGRAM_NOISE_FLOOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define RHNF_AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rhnf assertion failed");

// Next-cycle implication, disabled while in reset
`define RHNF_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rhnf assertion failed");

`endif

// ===== design/rhnf_pkg.sv =====
// Shared types and constants of the RSSI histogram noise-floor block.
// No dependencies; imported by rhnf_front, rhnf_back and the top level.
package rhnf_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int MIN_W      = 9;
  localparam int BWID_W     = 6;
  localparam int FLOOR_W    = 12;
  localparam int COUNT_W    = 16;
  localparam int DIFF_W     = 11;
  localparam int QUOT_W     = 10;
  localparam int REM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIST_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIN_WIDTH = 2'd1;

  localparam logic [MIN_W-1:0]   HIST_MIN_RST  = 9'h160;  // -160
  localparam logic [BWID_W-1:0]  BIN_WIDTH_RST = 6'd2;
  localparam logic [COUNT_W-1:0] MIN_FOR_VALID = 16'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [7:0]         ANALYSE_MASK  = 8'hFF;

  typedef struct packed {
    logic signed [MIN_W-1:0] hist_min;
    logic [BWID_W-1:0]       bin_width;
  } cfg_t;

  // status from the back end
  typedef struct packed {
    logic clr_done;   // bin store sweep finished
    logic analysing;  // peak search or floor update in progress
  } back_stat_t;

  // zero width is treated as one
  function automatic logic [BWID_W-1:0] eff_width(input logic [BWID_W-1:0] w);
    return (w == '0) ? BWID_W'(1) : w;
  endfunction

endpackage

// ===== design/rhnf_front.sv =====
// Front end: accepts samples and computes the clamped bin index.
// Bin = (sample - hist_min) / width via a bit-serial restoring divider. Uses rhnf_pkg.
module rhnf_front #(
  parameter int NUM_BINS = 64,
  parameter int BIN_W    = 6
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rhnf_pkg::cfg_t                        cfg_i,
  input  logic                                  en_i,
  input  logic                                  s_valid_i,
  output logic                                  s_ready_o,
  input  logic                                  s_chan_i,
  input  logic signed [rhnf_pkg::SAMPLE_W-1:0]  s_sample_i,
  output logic                                  q_valid_o,
  input  logic                                  q_ready_i,
  output logic                                  q_chan_o,
  output logic [BIN_W-1:0]                      q_bin_o
);
  import rhnf_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);
  localparam logic [QUOT_W-1:0] BIN_LAST = QUOT_W'(NUM_BINS - 1);

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q;
  logic [QUOT_W-1:0]      num_q, quot_q;
  logic [REM_W-1:0]       rem_q;
  logic [BWID_W-1:0]      wid_q;
  logic                   chan_q;
  logic signed [DIFF_W-1:0] diff;
  logic [REM_W-1:0]       trial;
  logic                   qbit;
  logic                   accept;

  // difference from the lower histogram edge
  assign diff = {{(DIFF_W-SAMPLE_W){s_sample_i[SAMPLE_W-1]}}, s_sample_i}
              - {{(DIFF_W-MIN_W){cfg_i.hist_min[MIN_W-1]}}, cfg_i.hist_min};

  // one quotient bit per cycle
  assign trial = {rem_q[REM_W-2:0], num_q[QUOT_W-1]};
  assign qbit  = (trial >= {1'b0, wid_q});

  assign s_ready_o = en_i && (state_q == F_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign q_valid_o = (state_q == F_PUSH);
  assign q_chan_o  = chan_q;
  assign q_bin_o   = (quot_q > BIN_LAST) ? BIN_LAST[BIN_W-1:0] : quot_q[BIN_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = F_DIV;
      F_DIV:  if (cnt_q == CNT_LAST) state_d = F_PUSH;
      F_PUSH: if (q_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q <= s_chan_i;
      num_q  <= diff[DIFF_W-1] ? '0 : diff[QUOT_W-1:0];
      rem_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      wid_q  <= eff_width(cfg_i.bin_width);
    end else if (state_q == F_DIV) begin
      num_q  <= {num_q[QUOT_W-2:0], 1'b0};
      rem_q  <= qbit ? (trial - {1'b0, wid_q}) : trial;
      quot_q <= {quot_q[QUOT_W-2:0], qbit};
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

endmodule

// ===== design/rhnf_fifo.sv =====
// Two-entry queue between the front and back ends.
// Generic payload width; no package dependency.
module rhnf_fifo #(
  parameter int W = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_data_i;
  end

endmodule

// ===== design/rhnf_back.sv =====
// Back end: bin count store, per-channel totals, peak search and floor update.
// Holds the result register of the output stream. Uses rhnf_pkg.
module rhnf_back #(
  parameter int NUM_BINS = 64,
  parameter int BIN_W    = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rhnf_pkg::cfg_t                       cfg_i,
  output rhnf_pkg::back_stat_t                 stat_o,
  input  logic                                 q_valid_i,
  output logic                                 q_ready_o,
  input  logic                                 q_chan_i,
  input  logic [BIN_W-1:0]                     q_bin_i,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic                                 m_chan_o,
  output logic signed [rhnf_pkg::FLOOR_W-1:0]  m_floor_o,
  output logic                                 m_fvalid_o,
  output logic                                 m_analysed_o
);
  import rhnf_pkg::*;

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_UPD   = 3'd2;
  localparam logic [2:0] B_SCAN  = 3'd3;
  localparam logic [2:0] B_DRAIN = 3'd4;
  localparam logic [2:0] B_MUL   = 3'd5;
  localparam logic [2:0] B_FLOOR = 3'd6;

  localparam int ADDR_W    = BIN_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int PROD_W    = BIN_W + BWID_W;
  localparam int SUM_W     = (PROD_W + 2 > FLOOR_W + 1) ? PROD_W + 2 : FLOOR_W + 1;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [BIN_W-1:0]  SCAN_LAST = BIN_W'(NUM_BINS - 1);
  localparam logic signed [SUM_W-1:0] FLOOR_MAX_S =
    {{(SUM_W-FLOOR_W+1){1'b0}}, {(FLOOR_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] FLOOR_MIN_S =
    {{(SUM_W-FLOOR_W+1){1'b1}}, {(FLOOR_W-1){1'b0}}};

  logic [2:0]               state_q, state_d;
  logic [COUNT_W-1:0]       mem [MEM_DEPTH];
  logic [COUNT_W-1:0]       rd_q;
  logic                     we, re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic [COUNT_W-1:0]       wdata;
  logic [ADDR_W-1:0]        clr_addr_q;
  logic                     chan_q;
  logic [BIN_W-1:0]         bin_q;
  logic [COUNT_W-1:0]       tot_q [2];
  logic signed [FLOOR_W-1:0] floor_q [2];
  logic                     fvalid_q [2];
  logic [COUNT_W-1:0]       total_d;
  logic                     trig, short_run;
  logic [BIN_W-1:0]         scan_idx_q, cmp_idx_q, peak_q;
  logic                     cmp_vld_q;
  logic [COUNT_W-1:0]       best_q;
  logic [PROD_W-1:0]        prod_q;
  logic [BWID_W-1:0]        wid;
  logic signed [SUM_W-1:0]  sum;
  logic signed [FLOOR_W-1:0] floor_new;
  logic                     pop;
  logic                     m_valid_q, m_chan_q, m_fvalid_q, m_analysed_q;
  logic signed [FLOOR_W-1:0] m_floor_q;

  assign wid = eff_width(cfg_i.bin_width);

  // handshake with the queue and status
  assign q_ready_o        = (state_q == B_IDLE) && !m_valid_q;
  assign pop              = q_valid_i && q_ready_o;
  assign stat_o.clr_done  = (state_q != B_CLEAR);
  assign stat_o.analysing = (state_q == B_SCAN) || (state_q == B_DRAIN) ||
                            (state_q == B_MUL)  || (state_q == B_FLOOR);

  // counter update and analysis trigger
  assign total_d   = tot_q[chan_q] + COUNT_W'(1);
  assign trig      = ((total_d[7:0] & ANALYSE_MASK) == 8'h00);
  assign short_run = (total_d < MIN_FOR_VALID);

  // floor = min + peak * width + width / 2, saturated
  assign sum = {{(SUM_W-MIN_W){cfg_i.hist_min[MIN_W-1]}}, cfg_i.hist_min}
             + {{(SUM_W-PROD_W){1'b0}}, prod_q}
             + {{(SUM_W-BWID_W+1){1'b0}}, wid[BWID_W-1:1]};

  always_comb begin
    if (sum > FLOOR_MAX_S) begin
      floor_new = FLOOR_MAX_S[FLOOR_W-1:0];
    end else if (sum < FLOOR_MIN_S) begin
      floor_new = FLOOR_MIN_S[FLOOR_W-1:0];
    end else begin
      floor_new = sum[FLOOR_W-1:0];
    end
  end

  // memory port control and next state
  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = {chan_q, bin_q};
    wdata   = (rd_q == COUNT_MAX) ? rd_q : rd_q + COUNT_W'(1);
    re      = 1'b0;
    raddr   = {q_chan_i, q_bin_i};
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_q;
        wdata = '0;
        if (clr_addr_q == ADDR_LAST) state_d = B_IDLE;
      end
      B_IDLE: begin
        re = pop;
        if (pop) state_d = B_UPD;
      end
      B_UPD: begin
        we = 1'b1;
        if (trig && !short_run) state_d = B_SCAN;
        else                    state_d = B_IDLE;
      end
      B_SCAN: begin
        re    = 1'b1;
        raddr = {chan_q, scan_idx_q};
        if (scan_idx_q == SCAN_LAST) state_d = B_DRAIN;
      end
      B_DRAIN: state_d = B_MUL;
      B_MUL:   state_d = B_FLOOR;
      B_FLOOR: state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // bin count store, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  // control state, per-channel state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      cmp_vld_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      tot_q[0]    <= '0;
      tot_q[1]    <= '0;
      floor_q[0]  <= '0;
      floor_q[1]  <= '0;
      fvalid_q[0] <= 1'b0;
      fvalid_q[1] <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == B_SCAN);
      if (state_q == B_CLEAR) clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (m_valid_q && m_ready_i) m_valid_q <= 1'b0;
      if (state_q == B_UPD) begin
        tot_q[chan_q] <= total_d;
        if (trig && short_run) fvalid_q[chan_q] <= 1'b0;
        if (!(trig && !short_run)) m_valid_q <= 1'b1;
      end
      if (state_q == B_FLOOR) begin
        floor_q[chan_q]  <= floor_new;
        fvalid_q[chan_q] <= 1'b1;
        m_valid_q        <= 1'b1;
      end
    end
  end

  // item, peak search and result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      chan_q <= q_chan_i;
      bin_q  <= q_bin_i;
    end
    if (state_q == B_UPD) begin
      scan_idx_q   <= '0;
      best_q       <= '0;
      peak_q       <= '0;
      m_chan_q     <= chan_q;
      m_floor_q    <= floor_q[chan_q];
      m_fvalid_q   <= trig ? 1'b0 : fvalid_q[chan_q];
      m_analysed_q <= trig;
    end
    if (state_q == B_SCAN) begin
      scan_idx_q <= scan_idx_q + BIN_W'(1);
      cmp_idx_q  <= scan_idx_q;
    end
    // first bin with the highest count wins
    if (cmp_vld_q && (rd_q > best_q)) begin
      best_q <= rd_q;
      peak_q <= cmp_idx_q;
    end
    if (state_q == B_MUL) prod_q <= PROD_W'(peak_q) * PROD_W'(wid);
    if (state_q == B_FLOOR) begin
      m_floor_q    <= floor_new;
      m_fvalid_q   <= 1'b1;
      m_analysed_q <= 1'b1;
    end
  end

  assign m_valid_o    = m_valid_q;
  assign m_chan_o     = m_chan_q;
  assign m_floor_o    = m_floor_q;
  assign m_fvalid_o   = m_fvalid_q;
  assign m_analysed_o = m_analysed_q;

endmodule

// ===== design/rssi_histogram_noise_floor_top.sv =====
// Top level of the two-channel RSSI histogram noise-floor estimator.
// Uses rhnf_pkg, rhnf_front, rhnf_fifo, rhnf_back and the assertion macro header.

// Each accepted sample (channel in tuser, dBm in tdata) is binned and counted in
// that channel's histogram and produces exactly one result: the channel's current
// noise floor, its valid flag and whether this sample ran a peak analysis. The
// front end takes a new sample only after its bit-serial bin divider has handed
// the last one to the queue. The back end reads and rewrites each sample's bin
// count on the single read port of the bin count memory and takes the next one
// only when idle; every 256th sample of a channel adds a peak search over that
// channel's bins. A two-entry queue separates the two ends and a result register
// holds the output, so new samples are taken while a result waits. After reset
// all 2 * 2**clog2(NUM_BINS) entries of the bin memory (128 at the default) are
// cleared, during which s_axis_tready stays low; configuration writes are accepted
// at any time but must only be made while no sample is in flight.
`include "rssi_histogram_noise_floor_top_assert.svh"

module rssi_histogram_noise_floor_top #(
  parameter int NUM_BINS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [rhnf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rhnf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // [9:0] rssi_sample
  input  logic [0:0]                          s_axis_tuser,  // [0] channel
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,  // [11:0] noise_floor
  output logic [2:0]                          m_axis_tuser   // [0] out_channel,
                                                             // [1] floor_valid, [2] analysed
);
  import rhnf_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int QW    = BIN_W + 1;

  cfg_t        cfg_q;
  back_stat_t  stat;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  logic        fq_chan, bq_chan;
  logic [BIN_W-1:0] fq_bin, bq_bin;
  logic [QW-1:0]    bq_data;
  logic        out_chan, out_fvalid, out_analysed;
  logic signed [FLOOR_W-1:0] out_floor;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hist_min  <= HIST_MIN_RST;
      cfg_q.bin_width <= BIN_WIDTH_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_HIST_MIN) begin
        cfg_q.hist_min <= cfg_wdata_i[MIN_W-1:0];
      end else if (cfg_idx_i == CFG_IDX_BIN_WIDTH) begin
        cfg_q.bin_width <= cfg_wdata_i[BWID_W-1:0];
      end
    end
  end

  rhnf_front #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .en_i       (stat.clr_done),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_chan_i   (s_axis_tuser[0]),
    .s_sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_chan_o   (fq_chan),
    .q_bin_o    (fq_bin)
  );

  rhnf_fifo #(
    .W (QW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  ({fq_chan, fq_bin}),
    .rd_valid_o (bq_valid),
    .rd_ready_i (bq_ready),
    .rd_data_o  (bq_data)
  );

  assign bq_chan = bq_data[QW-1];
  assign bq_bin  = bq_data[BIN_W-1:0];

  rhnf_back #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .stat_o       (stat),
    .q_valid_i    (bq_valid),
    .q_ready_o    (bq_ready),
    .q_chan_i     (bq_chan),
    .q_bin_i      (bq_bin),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_chan_o     (out_chan),
    .m_floor_o    (out_floor),
    .m_fvalid_o   (out_fvalid),
    .m_analysed_o (out_analysed)
  );

  assign m_axis_tdata = {4'b0000, out_floor};
  assign m_axis_tuser = {out_analysed, out_fvalid, out_chan};

  // no samples taken before the bin store is cleared
  `RHNF_AST_IMPL(a_ready_after_clear, s_axis_tready, stat.clr_done)
  // divider is busy for the cycle after a transaction
  `RHNF_AST_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // result register stays empty while a peak search runs
  `RHNF_AST_IMPL(a_no_result_in_scan, stat.analysing, !m_axis_tvalid)

endmodule
